// ----- sv/obr_pkg.sv -----
// ----------------------------------------------------------------------------
// obr_pkg
// Shared request codes, result beat type and queue sizing for the
// overwriting broadcast ring.
// ----------------------------------------------------------------------------
package obr_pkg;

    // Default ring geometry
    localparam int RING_DEPTH_DEF = 256;
    localparam int FRAME_BITS_DEF = 64;

    // Fixed field widths of the channel payload
    localparam int REQ_W   = 2;
    localparam int WORD_W  = 64;
    localparam int AVAIL_W = 9;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_WRITE = 2'd0;
    localparam logic [REQ_W-1:0] REQ_READ  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_AVAIL = 2'd2;

    // Status codes
    localparam logic ST_DONE  = 1'b0;
    localparam logic ST_EMPTY = 1'b1;

    // Result queue between front and back
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic               status;
        logic [WORD_W-1:0]  frame_out;
        logic [WORD_W-1:0]  next_position;
        logic [AVAIL_W-1:0] available_count;
    } t_result;

endpackage

// ----- sv/overwriting_broadcast_ring.sv -----
// ----------------------------------------------------------------------------
// overwriting_broadcast_ring
// Broadcast frame ring shared by many readers; writes overwrite the oldest
// frame, reads and queries answer against the running write count.
// Path: each result beat is registered in the front's result stage, then
// in the result queue, then in the back's output register.
// Throughput: one request per cycle, set by the single ring RAM port pair;
// a full result queue holds o_ready low until the back drains it.
// Reset: write count, slot pointer and queue clear; ring contents are
// undefined until written, so no clearing pass is run.
// ----------------------------------------------------------------------------
module overwriting_broadcast_ring #(
    parameter int RING_DEPTH = obr_pkg::RING_DEPTH_DEF,
    parameter int FRAME_BITS = obr_pkg::FRAME_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [obr_pkg::REQ_W-1:0]    i_req_type,
    input  logic [obr_pkg::WORD_W-1:0]   i_frame_data,
    input  logic [obr_pkg::WORD_W-1:0]   i_reader_position,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic                         o_status,
    output logic [obr_pkg::WORD_W-1:0]   o_frame_out,
    output logic [obr_pkg::WORD_W-1:0]   o_next_position,
    output logic [obr_pkg::AVAIL_W-1:0]  o_available_count
);

    logic                    w_push;
    obr_pkg::t_result        w_push_res;
    logic                    w_pop;
    logic                    w_nonempty;
    obr_pkg::t_result        w_head;
    logic [obr_pkg::QCW-1:0] w_count;
    obr_pkg::t_result        w_out;

    obr_front #(
        .RING_DEPTH (RING_DEPTH),
        .FRAME_BITS (FRAME_BITS)
    ) u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_req_type        (i_req_type),
        .i_frame_data      (i_frame_data),
        .i_reader_position (i_reader_position),
        .i_queue_count     (w_count),
        .o_push            (w_push),
        .o_push_res        (w_push_res)
    );

    obr_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_push_res (w_push_res),
        .i_pop      (w_pop),
        .o_nonempty (w_nonempty),
        .o_head     (w_head),
        .o_count    (w_count)
    );

    obr_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_nonempty (w_nonempty),
        .i_head     (w_head),
        .o_pop      (w_pop),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_res      (w_out)
    );

    // Unpack the result beat onto the output fields
    assign o_status          = w_out.status;
    assign o_frame_out       = w_out.frame_out;
    assign o_next_position   = w_out.next_position;
    assign o_available_count = w_out.available_count;

endmodule

// ----- sv/obr_ram.sv -----
// ----------------------------------------------------------------------------
// obr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module obr_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/obr_front.sv -----
// ----------------------------------------------------------------------------
// obr_front
// Accepts request beats, classifies them against the write count, performs
// the ring access and hands a finished result beat to the queue.
// ----------------------------------------------------------------------------
module obr_front #(
    parameter int RING_DEPTH = obr_pkg::RING_DEPTH_DEF,
    parameter int FRAME_BITS = obr_pkg::FRAME_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [obr_pkg::REQ_W-1:0]   i_req_type,
    input  logic [obr_pkg::WORD_W-1:0]  i_frame_data,
    input  logic [obr_pkg::WORD_W-1:0]  i_reader_position,
    input  logic [obr_pkg::QCW-1:0]     i_queue_count,
    output logic                        o_push,
    output obr_pkg::t_result            o_push_res
);

    localparam int AW = $clog2(RING_DEPTH);
    localparam int DW = AW + 1;
    localparam int UW = obr_pkg::QCW + 1;

    logic [obr_pkg::WORD_W-1:0] r_write_count;
    logic [obr_pkg::WORD_W-1:0] n_write_count;
    logic [AW-1:0]              r_wr_slot;
    logic [AW-1:0]              n_wr_slot;
    logic                       r_s1_valid;
    logic                       r_s1_is_frame;
    obr_pkg::t_result           r_s1_res;
    obr_pkg::t_result           n_s1_res;
    logic                       n_s1_is_frame;

    logic                       w_accept;
    logic [UW-1:0]              w_used;
    logic                       w_caught_up;
    logic [obr_pkg::WORD_W-1:0] w_dist;
    logic                       w_lapped;
    logic [DW-1:0]              w_dist_low;
    logic [DW-1:0]              w_wr_slot_ext;
    logic [AW-1:0]              w_slot_inc;
    logic [AW-1:0]              w_back_slot;
    logic [AW-1:0]              w_rd_slot;
    logic [obr_pkg::WORD_W-1:0] w_lap_next;
    logic [DW-1:0]              w_avail_cap;
    logic                       w_we;
    logic                       w_re;
    logic [FRAME_BITS-1:0]      w_rdata;

    // Hold off when the queue has no room for this beat and the one in flight
    assign w_used   = UW'(i_queue_count) + UW'(r_s1_valid);
    assign o_ready  = w_used < UW'(obr_pkg::QDEPTH);
    assign w_accept = i_valid && o_ready;

    // Position against write count
    assign w_caught_up   = i_reader_position >= r_write_count;
    assign w_dist        = r_write_count - i_reader_position;
    assign w_lapped      = w_dist > obr_pkg::WORD_W'(RING_DEPTH);
    assign w_dist_low    = w_dist[AW:0];
    assign w_wr_slot_ext = {1'b0, r_wr_slot};
    assign w_lap_next    = r_write_count - obr_pkg::WORD_W'(RING_DEPTH)
                           + obr_pkg::WORD_W'(2);

    // Slot after the write slot, wrapping at the ring depth
    assign w_slot_inc = (r_wr_slot == AW'(RING_DEPTH - 1)) ? '0 : r_wr_slot + AW'(1);

    // Slot of the reader position, counted back from the write slot
    always_comb begin
        if (w_wr_slot_ext >= w_dist_low) begin
            w_back_slot = AW'(w_wr_slot_ext - w_dist_low);
        end else begin
            w_back_slot = AW'(w_wr_slot_ext + DW'(RING_DEPTH) - w_dist_low);
        end
    end

    // A lapped reader restarts at the frame after the oldest one still held
    assign w_rd_slot   = w_lapped ? w_slot_inc : w_back_slot;
    assign w_avail_cap = w_lapped ? DW'(RING_DEPTH) : w_dist_low;

    assign w_we = w_accept && (i_req_type == obr_pkg::REQ_WRITE);
    assign w_re = w_accept && (i_req_type == obr_pkg::REQ_READ) && !w_caught_up;

    obr_ram #(
        .WIDTH (FRAME_BITS),
        .DEPTH (RING_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_wr_slot),
        .i_wdata (i_frame_data[FRAME_BITS-1:0]),
        .i_re    (w_re),
        .i_raddr (w_rd_slot),
        .o_rdata (w_rdata)
    );

    // Decode the request into a result beat and the next write state
    always_comb begin
        n_s1_res      = '0;
        n_s1_is_frame = 1'b0;
        n_write_count = r_write_count;
        n_wr_slot     = r_wr_slot;
        unique case (i_req_type)
            obr_pkg::REQ_WRITE: begin
                n_write_count = r_write_count + obr_pkg::WORD_W'(1);
                n_wr_slot     = w_slot_inc;
            end
            obr_pkg::REQ_READ: begin
                if (w_caught_up) begin
                    n_s1_res.status        = obr_pkg::ST_EMPTY;
                    n_s1_res.next_position = i_reader_position;
                end else begin
                    n_s1_is_frame          = 1'b1;
                    n_s1_res.next_position = w_lapped ? w_lap_next
                                             : i_reader_position + obr_pkg::WORD_W'(1);
                end
            end
            obr_pkg::REQ_AVAIL: begin
                n_s1_res.next_position   = i_reader_position;
                n_s1_res.available_count = w_caught_up ? '0
                                           : obr_pkg::AVAIL_W'(w_avail_cap);
            end
            default: begin
                n_s1_res = '0;
            end
        endcase
    end

    // Advance write state and the result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_write_count <= '0;
            r_wr_slot     <= '0;
            r_s1_valid    <= 1'b0;
        end else begin
            r_s1_valid <= w_accept;
            if (w_accept) begin
                r_write_count <= n_write_count;
                r_wr_slot     <= n_wr_slot;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_res      <= n_s1_res;
            r_s1_is_frame <= n_s1_is_frame;
        end
    end

    // Merge the ring read data into the beat
    always_comb begin
        o_push_res = r_s1_res;
        if (r_s1_is_frame) begin
            o_push_res.frame_out = obr_pkg::WORD_W'(w_rdata);
        end
    end

    assign o_push = r_s1_valid;

endmodule

// ----- sv/obr_queue.sv -----
// ----------------------------------------------------------------------------
// obr_queue
// Short result queue between the front and the back.
// ----------------------------------------------------------------------------
module obr_queue (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    input  obr_pkg::t_result        i_push_res,
    input  logic                    i_pop,
    output logic                    o_nonempty,
    output obr_pkg::t_result        o_head,
    output logic [obr_pkg::QCW-1:0] o_count
);

    obr_pkg::t_result        r_entry [obr_pkg::QDEPTH];
    logic [obr_pkg::QAW-1:0] r_wr_ptr;
    logic [obr_pkg::QAW-1:0] r_rd_ptr;
    logic [obr_pkg::QCW-1:0] r_count;
    logic [obr_pkg::QCW-1:0] n_count;

    // Track fill level
    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + obr_pkg::QCW'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - obr_pkg::QCW'(1);
        end
    end

    // Advance pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + obr_pkg::QAW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + obr_pkg::QAW'(1);
            end
        end
    end

    // Store the pushed beat
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_push_res;
        end
    end

    assign o_head     = r_entry[r_rd_ptr];
    assign o_nonempty = r_count != '0;
    assign o_count    = r_count;

endmodule

// ----- sv/obr_back.sv -----
// ----------------------------------------------------------------------------
// obr_back
// Output register: pulls result beats from the queue and presents them
// on the output channel.
// ----------------------------------------------------------------------------
module obr_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_nonempty,
    input  obr_pkg::t_result i_head,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output obr_pkg::t_result o_res
);

    logic             r_valid;
    obr_pkg::t_result r_res;

    // Load when the register is free or being drained
    assign o_pop = i_nonempty && (!r_valid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_res <= i_head;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

// ----- tb/sv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the overwriting broadcast ring. A mirror of the
// write count and frame slots predicts every result beat as each request beat
// is taken. Directed cases cover unused codes, empty reads and queries, and
// lapped readers. Random traffic mixes writes, reads and queries under
// several sender and receiver idling profiles.
// ----------------------------------------------------------------------------
module tb;
    import obr_pkg::*;

    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam int DEPTH       = RING_DEPTH_DEF;
    localparam int SLOT_W      = $clog2(DEPTH);
    localparam int LATENCY     = 3;
    localparam int CYCLE_LIMIT = 200000;
    localparam logic [WORD_W-1:0] ALL_ONES = '1;

    logic               i_clk             = 1'b0;
    logic               i_rst_n           = 1'b0;
    logic               i_valid           = 1'b0;
    logic               o_ready;
    logic [REQ_W-1:0]   i_req_type        = '0;
    logic [WORD_W-1:0]  i_frame_data      = '0;
    logic [WORD_W-1:0]  i_reader_position = '0;
    logic               o_valid;
    logic               i_ready           = 1'b0;
    logic               o_status;
    logic [WORD_W-1:0]  o_frame_out;
    logic [WORD_W-1:0]  o_next_position;
    logic [AVAIL_W-1:0] o_available_count;

    // Mirror of the ring state
    logic [WORD_W-1:0] mirror_count = '0;
    logic [WORD_W-1:0] mirror_slots [DEPTH];

    t_result awaited_answers [$];
    t_result last_answer;
    logic [WORD_W-1:0] follower_pos [4] = '{default: '0};

    int idle_pct    = 0;
    int stall_pct   = 0;
    int cycle_count = 0;
    int error_count = 0;
    int n_requests  = 0;
    int n_writes    = 0;
    int n_frames    = 0;
    int n_empty     = 0;
    int n_laps      = 0;
    int n_queries   = 0;

    overwriting_broadcast_ring dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_req_type        (i_req_type),
        .i_frame_data      (i_frame_data),
        .i_reader_position (i_reader_position),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_status          (o_status),
        .o_frame_out       (o_frame_out),
        .o_next_position   (o_next_position),
        .o_available_count (o_available_count)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Stall the result channel at random
    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Guard against a hung run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: errors");
            $finish;
        end
    end

    // Work out the answer to one request and advance the mirror
    function automatic t_result ring_answer(input logic [REQ_W-1:0] kind,
                                            input logic [WORD_W-1:0] word,
                                            input logic [WORD_W-1:0] pos);
        t_result ans;
        logic [WORD_W-1:0] gap;
        ans = '0;
        case (kind)
            REQ_WRITE: begin
                mirror_slots[mirror_count[SLOT_W-1:0]] = word;
                mirror_count = mirror_count + 64'd1;
                n_writes++;
            end
            REQ_READ: begin
                if (pos >= mirror_count) begin
                    ans.status        = ST_EMPTY;
                    ans.next_position = pos;
                    n_empty++;
                end else begin
                    // Skip a lapped reader up to the frame after the oldest one still held
                    if (mirror_count - pos > 64'(DEPTH)) begin
                        pos = mirror_count - 64'(DEPTH) + 64'd1;
                        n_laps++;
                    end
                    ans.status        = ST_DONE;
                    ans.frame_out     = mirror_slots[pos[SLOT_W-1:0]];
                    ans.next_position = pos + 64'd1;
                    n_frames++;
                end
            end
            REQ_AVAIL: begin
                if (mirror_count > pos) begin
                    gap = mirror_count - pos;
                    ans.available_count = (gap > 64'(DEPTH)) ? AVAIL_W'(DEPTH)
                                                             : gap[AVAIL_W-1:0];
                end
                ans.next_position = pos;
                n_queries++;
            end
            default: begin
            end
        endcase
        return ans;
    endfunction

    function automatic void check_field(input string name, input logic [WORD_W-1:0] want,
                                        input logic [WORD_W-1:0] got);
        if (want !== got) begin
            $error("%s: expected %h, got %h", name, want, got);
            error_count++;
        end
    endfunction

    // Compare each result beat with the oldest awaited answer
    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (awaited_answers.size() == 0) begin
                $error("result beat with no request awaiting it");
                error_count++;
            end else begin
                want = awaited_answers.pop_front();
                check_field("status", 64'(want.status), 64'(o_status));
                check_field("frame_out", want.frame_out, o_frame_out);
                check_field("next_position", want.next_position, o_next_position);
                check_field("available_count", 64'(want.available_count),
                            64'(o_available_count));
            end
        end
    end

    // Send one request beat, idling first at random
    task automatic send_request(input logic [REQ_W-1:0] kind,
                                input logic [WORD_W-1:0] word,
                                input logic [WORD_W-1:0] pos);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid           <= 1'b1;
        i_req_type        <= kind;
        i_frame_data      <= word;
        i_reader_position <= pos;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        last_answer = ring_answer(kind, word, pos);
        awaited_answers.push_back(last_answer);
        n_requests++;
    endtask

    // Drop valid and hold until every awaited answer is back
    task automatic drain_answers();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (awaited_answers.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 5) @(posedge i_clk);
    endtask

    function automatic logic [WORD_W-1:0] pick_position();
        logic [WORD_W-1:0] back;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: back = 64'($urandom_range(1, 16));
            4, 5:       back = 64'($urandom_range(1, 300));
            6:          back = 64'($urandom_range(254, 259));
            7:          return mirror_count + 64'($urandom_range(0, 3));
            default:    return {$urandom, $urandom};
        endcase
        return (back > mirror_count) ? '0 : mirror_count - back;
    endfunction

    function automatic logic [REQ_W-1:0] pick_kind();
        int v;
        v = $urandom_range(0, 99);
        if (v < 38) return REQ_WRITE;
        if (v < 75) return REQ_READ;
        if (v < 95) return REQ_AVAIL;
        return REQ_UNUSED;
    endfunction

    // Unused code, empty ring, field extremes and simple reads and queries
    task automatic test_directed_cases();
        send_request(REQ_UNUSED, ALL_ONES, ALL_ONES);
        send_request(REQ_READ, '0, '0);
        send_request(REQ_AVAIL, ALL_ONES, '0);
        send_request(REQ_READ, '0, ALL_ONES);
        send_request(REQ_WRITE, '0, ALL_ONES);
        send_request(REQ_WRITE, ALL_ONES, '0);
        send_request(REQ_WRITE, 64'h8000_0000_0000_0001, '0);
        send_request(REQ_WRITE, 64'h5555_5555_5555_5555, '0);
        send_request(REQ_WRITE, 64'hAAAA_AAAA_AAAA_AAAA, '0);
        send_request(REQ_READ, '0, 64'd0);
        send_request(REQ_READ, '0, 64'd1);
        send_request(REQ_READ, '0, 64'd4);
        send_request(REQ_READ, '0, 64'd5);
        send_request(REQ_AVAIL, '0, 64'd0);
        send_request(REQ_AVAIL, '0, 64'd3);
        send_request(REQ_AVAIL, '0, 64'd5);
        send_request(REQ_AVAIL, '0, ALL_ONES);
        send_request(REQ_UNUSED, '0, '0);
        drain_answers();
    endtask

    // Lap the ring, then read and query around the depth boundary
    task automatic test_lapped_reader();
        int gaps [5] = '{1, 255, 256, 257, 258};
        int k;
        for (k = 0; k < 262; k++) begin
            send_request(REQ_WRITE, {$urandom, $urandom}, {$urandom, $urandom});
        end
        foreach (gaps[g]) begin
            send_request(REQ_READ, '0, mirror_count - 64'(gaps[g]));
            send_request(REQ_AVAIL, '0, mirror_count - 64'(gaps[g]));
        end
        send_request(REQ_READ, '0, '0);
        send_request(REQ_AVAIL, '0, '0);
        drain_answers();
    endtask

    // Mixed traffic; half the reads follow a reader's own running position
    task automatic test_random_traffic(input int count);
        logic [REQ_W-1:0] kind;
        logic [WORD_W-1:0] pos;
        int r;
        bit tracked;
        repeat (count) begin
            kind    = pick_kind();
            r       = $urandom_range(0, 3);
            tracked = ($urandom_range(0, 1) == 0);
            pos     = tracked ? follower_pos[r] : pick_position();
            send_request(kind, {$urandom, $urandom}, pos);
            if (tracked && kind == REQ_READ) follower_pos[r] = last_answer.next_position;
        end
        drain_answers();
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_cases();

        idle_pct  = 0;
        stall_pct = 47;
        test_lapped_reader();

        idle_pct  = 0;
        stall_pct = 0;
        test_random_traffic(415);
        idle_pct  = 47;
        stall_pct = 0;
        test_random_traffic(415);
        idle_pct  = 0;
        stall_pct = 47;
        test_random_traffic(415);
        idle_pct  = 35;
        stall_pct = 35;
        test_random_traffic(415);

        $display("tb: %0d requests: %0d writes, %0d frames read, %0d empty reads",
                 n_requests, n_writes, n_frames, n_empty);
        $display("tb: %0d lapped-reader skips, %0d availability queries",
                 n_laps, n_queries);
        if (error_count == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
sv/obr_pkg.sv
sv/obr_ram.sv
sv/obr_front.sv
sv/obr_queue.sv
sv/obr_back.sv
sv/overwriting_broadcast_ring.sv
tb/sv/tb.sv
